[src/assert_macros.svh]
// Assertion macros shared by the calibrate-and-filter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset
`define ACBQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed in the next cycle by another
`define ACBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ACBQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define ACBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/acbq_pkg.sv]
// Shared types, constants and gain table of the calibrate-and-filter block
`timescale 1ns / 1ps

package acbq_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int NUM_AXES   = 3;
	localparam int DATA_W     = 32;
	localparam int COEF_W     = 18;
	localparam int OFFS_W     = 24;
	localparam int GAIN_W     = 22;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int CAL_SHIFT = 10;
	localparam int ACC_SHIFT = 20;
	localparam int FB_SHIFT  = 4;

	// Multiplier operand and product widths
	localparam int MUL_A_W = GAIN_W;
	localparam int MUL_B_W = DATA_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Calibration sum: three gain by sample products
	localparam int CACC_W  = GAIN_W + SAMPLE_W + 2;
	localparam int CALSH_W = CACC_W - CAL_SHIFT;
	localparam int CAL_W   = (CALSH_W + 1 > DATA_W + 1) ? CALSH_W + 1 : DATA_W + 1;

	// Filter sum: five products, feedback terms scaled up
	localparam int ACC_W   = PROD_W + FB_SHIFT;
	localparam int ACCSH_W = ACC_W - ACC_SHIFT;

	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Fixed gain matrix, signed Q1.20, one row per output axis
	localparam logic signed [GAIN_W-1:0] GAIN [NUM_AXES][NUM_AXES] = '{
		'{ 22'sd1089766,   22'sd7498,    22'sd8650    },
		'{ -22'sd76995,    22'sd1030582, 22'sd25262   },
		'{ -22'sd110103,   -22'sd15026,  22'sd1060116 }
	};

	// Register reset values
	localparam logic signed [COEF_W-1:0] COEF_RST   = 18'sd13107;
	localparam logic signed [OFFS_W-1:0] OFFS_X_RST = 24'sd2323;
	localparam logic signed [OFFS_W-1:0] OFFS_Y_RST = 24'sd18591;
	localparam logic signed [OFFS_W-1:0] OFFS_Z_RST = -24'sd5486;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_B0,
		REG_B1,
		REG_B2,
		REG_A1,
		REG_A2,
		REG_OFF_X,
		REG_OFF_Y,
		REG_OFF_Z
	} reg_idx_t;

	// Sequencer steps; each G, B and A step names the product issued in that cycle
	typedef enum logic [3:0] {
		ST_G0,
		ST_G1,
		ST_G2,
		ST_B1,
		ST_B2,
		ST_A1,
		ST_A2,
		ST_B0,
		ST_LAST,
		ST_OUT
	} step_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] raw_x;
		logic signed [SAMPLE_W-1:0] raw_y;
		logic signed [SAMPLE_W-1:0] raw_z;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] filtered_x;
		logic signed [DATA_W-1:0] filtered_y;
		logic signed [DATA_W-1:0] filtered_z;
	} out_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_t;

	typedef struct packed {
		logic  run;
		step_t step;
		logic  done;
	} ctl_t;

endpackage

[src/acbq_lane.sv]
// One axis lane: calibration and biquad on a shared multiplier
`timescale 1ns / 1ps

module acbq_lane import acbq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_t                     ctl,
	input  logic [1:0]               axis,
	input  in_t                      raw,
	input  coef_t                    coef,
	input  logic signed [OFFS_W-1:0] offset,
	output logic signed [DATA_W-1:0] y
);

	localparam logic signed [CACC_W-1:0] CAL_HALF = CACC_W'(2 ** (CAL_SHIFT - 1));
	localparam logic signed [ACC_W-1:0]  ACC_HALF = ACC_W'(2 ** (ACC_SHIFT - 1));

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   prod_fb;
	logic signed [CACC_W-1:0]  cacc_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [CACC_W-1:0]  cal_rnd;
	logic signed [CALSH_W-1:0] cal_sh;
	logic signed [CAL_W-1:0]   cal_sum;
	logic [CAL_W-DATA_W:0]     cal_hi;
	logic signed [DATA_W-1:0]  cal_sat;
	logic signed [DATA_W-1:0]  cal_q;
	logic signed [ACC_W-1:0]   acc_rnd;
	logic signed [ACCSH_W-1:0] acc_sh;
	logic [ACCSH_W-DATA_W:0]   acc_hi;
	logic signed [DATA_W-1:0]  x1_q;
	logic signed [DATA_W-1:0]  x2_q;
	logic signed [DATA_W-1:0]  y1_q;
	logic signed [DATA_W-1:0]  y2_q;

	// Pick the multiplier operands for this step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.step)
			ST_G0: begin
				mul_a = GAIN[axis][0];
				mul_b = MUL_B_W'(raw.raw_x);
			end
			ST_G1: begin
				mul_a = GAIN[axis][1];
				mul_b = MUL_B_W'(raw.raw_y);
			end
			ST_G2: begin
				mul_a = GAIN[axis][2];
				mul_b = MUL_B_W'(raw.raw_z);
			end
			ST_B1: begin
				mul_a = MUL_A_W'(coef.b1);
				mul_b = x1_q;
			end
			ST_B2: begin
				mul_a = MUL_A_W'(coef.b2);
				mul_b = x2_q;
			end
			ST_A1: begin
				mul_a = MUL_A_W'(coef.a1);
				mul_b = y1_q;
			end
			ST_A2: begin
				mul_a = MUL_A_W'(coef.a2);
				mul_b = y2_q;
			end
			ST_B0: begin
				mul_a = MUL_A_W'(coef.b0);
				mul_b = cal_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Round the calibration sum to Q21.10, add the offset, saturate
	always_comb begin
		cal_rnd = cacc_q + CAL_HALF;
		cal_sh  = cal_rnd[CACC_W-1:CAL_SHIFT];
		cal_sum = CAL_W'(cal_sh) + CAL_W'(offset);
		cal_hi  = cal_sum[CAL_W-1:DATA_W-1];
		if (&cal_hi || ~|cal_hi) begin
			cal_sat = cal_sum[DATA_W-1:0];
		end else if (cal_sum[CAL_W-1]) begin
			cal_sat = DATA_MIN;
		end else begin
			cal_sat = DATA_MAX;
		end
	end

	// Round the filter sum to Q21.10 and saturate
	always_comb begin
		acc_rnd = acc_q + ACC_HALF;
		acc_sh  = acc_rnd[ACC_W-1:ACC_SHIFT];
		acc_hi  = acc_sh[ACCSH_W-1:DATA_W-1];
		if (&acc_hi || ~|acc_hi) begin
			y = acc_sh[DATA_W-1:0];
		end else if (acc_sh[ACCSH_W-1]) begin
			y = DATA_MIN;
		end else begin
			y = DATA_MAX;
		end
	end

	assign prod_ext = ACC_W'(prod_q);
	assign prod_fb  = prod_ext <<< FB_SHIFT;

	// Multiply, then accumulate the product issued in the previous step
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (ctl.run) begin
			case (ctl.step)
				ST_G1: begin
					cacc_q <= CACC_W'(prod_q);
				end
				ST_G2, ST_B1: begin
					cacc_q <= cacc_q + CACC_W'(prod_q);
				end
				ST_B2: begin
					acc_q <= prod_ext;
					cal_q <= cal_sat;
				end
				ST_A1, ST_LAST: begin
					acc_q <= acc_q + prod_ext;
				end
				ST_A2, ST_B0: begin
					acc_q <= acc_q + prod_fb;
				end
				default: begin
				end
			endcase
		end
	end

	// Shift the histories once the result is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (ctl.done) begin
			x2_q <= x1_q;
			x1_q <= cal_q;
			y2_q <= y1_q;
			y1_q <= y;
		end
	end

endmodule

[src/acbq_seq.sv]
// Step sequencer shared by the three axis lanes
`timescale 1ns / 1ps
`include "assert_macros.svh"

module acbq_seq import acbq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_free,
	output ctl_t ctl
);

	logic  run_q;
	step_t step_q;
	step_t step_next;

	// Walk the schedule in order
	always_comb begin
		case (step_q)
			ST_G0:   step_next = ST_G1;
			ST_G1:   step_next = ST_G2;
			ST_G2:   step_next = ST_B1;
			ST_B1:   step_next = ST_B2;
			ST_B2:   step_next = ST_A1;
			ST_A1:   step_next = ST_A2;
			ST_A2:   step_next = ST_B0;
			ST_B0:   step_next = ST_LAST;
			ST_LAST: step_next = ST_OUT;
			default: step_next = ST_G0;
		endcase
	end

	// Start on a transaction, hold on the final step until the result slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= ST_G0;
		end else if (in_fire) begin
			run_q  <= 1'b1;
			step_q <= ST_G0;
		end else if (run_q) begin
			if (step_q == ST_OUT) begin
				if (out_free) begin
					run_q  <= 1'b0;
					step_q <= ST_G0;
				end
			end else begin
				step_q <= step_next;
			end
		end
	end

	assign ctl.run  = run_q;
	assign ctl.step = step_q;
	assign ctl.done = run_q && (step_q == ST_OUT) && out_free;

	`ACBQ_ASSERT_NEXT(a_start, clk, arst_n, in_fire, ctl.run && ctl.step == ST_G0, "sample did not start the schedule")
	`ACBQ_ASSERT_NEXT(a_no_early_exit, clk, arst_n, ctl.run && ctl.step != ST_OUT, ctl.run, "schedule left before the final step")
	`ACBQ_ASSERT_NEXT(a_done_idle, clk, arst_n, ctl.done, !ctl.run, "lanes still running after handing on the result")
	`ACBQ_ASSERT(a_idle_step, clk, arst_n, !ctl.run |-> ctl.step == ST_G0, "idle sequencer not parked at the first step")

endmodule

[src/acbq_merge.sv]
// Result stage: gathers the lane outputs into one registered result
`timescale 1ns / 1ps

module acbq_merge import acbq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     done,
	input  logic signed [DATA_W-1:0] lane_y [NUM_AXES],
	input  logic                     out_ready,
	output logic                     out_valid,
	output out_t                     out_data,
	output logic                     out_free
);

	logic valid_q;
	out_t data_q;

	assign out_free = !valid_q || out_ready;

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (done) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the three axes together
	always_ff @(posedge clk) begin
		if (done) begin
			data_q.filtered_x <= lane_y[0];
			data_q.filtered_y <= lane_y[1];
			data_q.filtered_z <= lane_y[2];
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

[src/accel_calibrate_biquad_filter_top.sv]
// Top level of the three-axis accelerometer calibrate-and-biquad block
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    in_data  (raw_x, raw_y, raw_z)
//   out      source     out_valid / out_ready  out_data (filtered_x/y/z)
//   cfg      sink       cfg_we                 cfg_idx, cfg_data
//
// After acceptance a sample walks the ten sequencer steps, ST_G0 to ST_OUT.
// Each axis lane has one 22x32 multiplier that issues eight products in turn
// (three calibration gains, five filter taps); that multiplier sets the rate.
// The result lands in the output register, so in_ready returns while it waits.
// With the output register full the lanes hold on the final step.
// Reset loads the register defaults and clears the filter histories.
`timescale 1ns / 1ps

module accel_calibrate_biquad_filter_top import acbq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_t                     ctl;
	logic                     in_fire;
	logic                     out_free;
	in_t                      in_q;
	coef_t                    coef_q;
	logic signed [OFFS_W-1:0] offset_q [NUM_AXES];
	logic signed [DATA_W-1:0] lane_y [NUM_AXES];

	assign in_ready = !ctl.run;
	assign in_fire  = in_valid && in_ready;

	// Capture the sample for the whole schedule
	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_q <= in_data;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0   <= COEF_RST;
			coef_q.b1   <= COEF_RST;
			coef_q.b2   <= COEF_RST;
			coef_q.a1   <= COEF_RST;
			coef_q.a2   <= COEF_RST;
			offset_q[0] <= OFFS_X_RST;
			offset_q[1] <= OFFS_Y_RST;
			offset_q[2] <= OFFS_Z_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_B0:    coef_q.b0   <= cfg_data[COEF_W-1:0];
				REG_B1:    coef_q.b1   <= cfg_data[COEF_W-1:0];
				REG_B2:    coef_q.b2   <= cfg_data[COEF_W-1:0];
				REG_A1:    coef_q.a1   <= cfg_data[COEF_W-1:0];
				REG_A2:    coef_q.a2   <= cfg_data[COEF_W-1:0];
				REG_OFF_X: offset_q[0] <= cfg_data[OFFS_W-1:0];
				REG_OFF_Y: offset_q[1] <= cfg_data[OFFS_W-1:0];
				REG_OFF_Z: offset_q[2] <= cfg_data[OFFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	acbq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.ctl      (ctl)
	);

	// One lane per axis
	for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
		acbq_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.axis   (2'(g)),
			.raw    (in_q),
			.coef   (coef_q),
			.offset (offset_q[g]),
			.y      (lane_y[g])
		);
	end

	acbq_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.done      (ctl.done),
		.lane_y    (lane_y),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_free  (out_free)
	);

endmodule
